// ===== sv/albt_pkg.sv =====
`timescale 1ns / 1ps
package albt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_SEGMENT = 2'd0;
    localparam logic [OP_W-1:0] OP_RAY     = 2'd1;
    localparam logic [OP_W-1:0] OP_LINE    = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    // per-lane side flags that ride along the divider
    localparam int SB_W = 4;
    typedef struct packed {
        logic neg;
        logic den_zero;
        logic num_zero;
        logic num_pos;
    } t_lane_flags;

    localparam int LANES = 6;

endpackage

// ===== sv/albt_div_step.sv =====
`timescale 1ns / 1ps
module albt_div_step #(
    parameter int W  = 32,
    parameter int SB = 4
) (
    input  logic          i_clk,
    input  logic [W-1:0]  i_n,
    input  logic [W-1:0]  i_d,
    input  logic [W-1:0]  i_r,
    input  logic [W-1:0]  i_q,
    input  logic          i_sat,
    input  logic [SB-1:0] i_sb,
    output logic [W-1:0]  o_n,
    output logic [W-1:0]  o_d,
    output logic [W-1:0]  o_r,
    output logic [W-1:0]  o_q,
    output logic          o_sat,
    output logic [SB-1:0] o_sb
);
    logic [W:0] rem2;
    logic [W:0] sub;
    logic       ge;

    assign rem2 = {i_r, i_n[W-1]};
    assign sub  = rem2 - {1'b0, i_d};
    assign ge   = rem2 >= {1'b0, i_d};

    logic [W-1:0]  r_n, r_d, r_r, r_q;
    logic          r_sat;
    logic [SB-1:0] r_sb;

    always_ff @(posedge i_clk) begin
        r_r   <= ge ? sub[W-1:0] : rem2[W-1:0];
        r_n   <= {i_n[W-2:0], 1'b0};
        r_q   <= {i_q[W-2:0], ge};
        // any quotient bit at or above the sign position means overflow
        r_sat <= i_sat | i_q[W-1];
        r_d   <= i_d;
        r_sb  <= i_sb;
    end

    assign o_n   = r_n;
    assign o_d   = r_d;
    assign o_r   = r_r;
    assign o_q   = r_q;
    assign o_sat = r_sat;
    assign o_sb  = r_sb;
endmodule

// ===== sv/albt_divider.sv =====
`timescale 1ns / 1ps
module albt_divider #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int SB = 4
) (
    input  logic          i_clk,
    input  logic [W-1:0]  i_n,
    input  logic [W-1:0]  i_d,
    input  logic [SB-1:0] i_sb,
    output logic [W-2:0]  o_q,
    output logic          o_sat,
    output logic [SB-1:0] o_sb
);
    localparam int N = W + F;

    logic [W-1:0]  s_n   [N+1];
    logic [W-1:0]  s_d   [N+1];
    logic [W-1:0]  s_r   [N+1];
    logic [W-1:0]  s_q   [N+1];
    logic          s_sat [N+1];
    logic [SB-1:0] s_sb  [N+1];

    assign s_n[0]   = i_n;
    assign s_d[0]   = i_d;
    assign s_r[0]   = '0;
    assign s_q[0]   = '0;
    assign s_sat[0] = 1'b0;
    assign s_sb[0]  = i_sb;

    for (genvar i = 0; i < N; i++) begin : g_step
        albt_div_step #(.W(W), .SB(SB)) u_step (
            .i_clk (i_clk),
            .i_n   (s_n[i]),
            .i_d   (s_d[i]),
            .i_r   (s_r[i]),
            .i_q   (s_q[i]),
            .i_sat (s_sat[i]),
            .i_sb  (s_sb[i]),
            .o_n   (s_n[i+1]),
            .o_d   (s_d[i+1]),
            .o_r   (s_r[i+1]),
            .o_q   (s_q[i+1]),
            .o_sat (s_sat[i+1]),
            .o_sb  (s_sb[i+1])
        );
    end

    assign o_q   = s_q[N][W-2:0];
    assign o_sat = s_sat[N] | s_q[N][W-1];
    assign o_sb  = s_sb[N];
endmodule

// ===== sv/albt_resolve.sv =====
`timescale 1ns / 1ps
module albt_resolve #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [albt_pkg::OP_W-1:0] i_op,
    input  logic [W-2:0]              i_q     [albt_pkg::LANES],
    input  logic                      i_sat   [albt_pkg::LANES],
    input  albt_pkg::t_lane_flags     i_flags [albt_pkg::LANES],
    output logic                      o_valid,
    output logic                      o_hit
);
    import albt_pkg::*;

    localparam longint LIM   = (longint'(1) << (W - 1)) - 1;
    localparam longint ONE_L = (1 > (LIM >> F)) ? LIM : (longint'(1) << F);
    localparam longint K99_L = (99 > (LIM >> F)) ? LIM : (longint'(99) << F);
    localparam logic signed [W-1:0] PMAX = W'(LIM);
    localparam logic signed [W-1:0] NMIN = ~PMAX;
    localparam logic signed [W-1:0] ONE  = W'(ONE_L);
    localparam logic signed [W-1:0] K99  = W'(K99_L);

    // stage 1: signed parameter per lane
    logic signed [W-1:0] n_t [LANES];
    logic signed [W-1:0] r_t [LANES];
    logic                r_v1;
    logic [OP_W-1:0]     r_op1;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (i_flags[k].den_zero) begin
                if (i_flags[k].num_zero) begin
                    n_t[k] = (k < 3) ? '0 : K99;
                end else begin
                    n_t[k] = i_flags[k].num_pos ? PMAX : NMIN;
                end
            end else if (i_sat[k]) begin
                n_t[k] = i_flags[k].neg ? NMIN : PMAX;
            end else begin
                n_t[k] = i_flags[k].neg ? -$signed({1'b0, i_q[k]}) : $signed({1'b0, i_q[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_op1 <= i_op;
    end

    // stage 2: near and far per axis
    logic signed [W-1:0] r_near [3];
    logic signed [W-1:0] r_far  [3];
    logic                r_v2;
    logic [OP_W-1:0]     r_op2;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (r_t[a] < r_t[a+3]) begin
                r_near[a] <= r_t[a];
                r_far[a]  <= r_t[a+3];
            end else begin
                r_near[a] <= r_t[a+3];
                r_far[a]  <= r_t[a];
            end
        end
        r_op2 <= r_op1;
    end

    // stage 3: largest near, smallest far
    logic signed [W-1:0] n_tmin, n_tmax;
    logic signed [W-1:0] r_tmin, r_tmax;
    logic                r_v3;
    logic [OP_W-1:0]     r_op3;

    always_comb begin
        n_tmin = r_near[0];
        n_tmax = r_far[0];
        for (int a = 1; a < 3; a++) begin
            if (r_near[a] > n_tmin) begin
                n_tmin = r_near[a];
            end
            if (r_far[a] < n_tmax) begin
                n_tmax = r_far[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmin <= n_tmin;
        r_tmax <= n_tmax;
        r_op3  <= r_op2;
    end

    // stage 4: hit decision
    logic n_hit;
    logic r_hit;
    logic r_v4;

    always_comb begin
        n_hit = 1'b0;
        if (r_tmin <= r_tmax) begin
            case (r_op3)
                OP_SEGMENT: n_hit = (r_tmin >= 0 && r_tmin <= ONE) ||
                                    (r_tmax >= 0 && r_tmax <= ONE) ||
                                    (r_tmin <= 0 && r_tmax >= ONE);
                OP_RAY:     n_hit = r_tmax >= 0;
                OP_LINE:    n_hit = 1'b1;
                default:    n_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_hit <= r_v3 & n_hit;
        end
    end

    assign o_valid = r_v4;
    assign o_hit   = r_hit;
endmodule

// ===== sv/aabb_line_slab_test_core.sv =====
`timescale 1ns / 1ps
// Slab test of a segment, ray or infinite line against the box held in the six
// bound registers. A query is taken whenever start is high; busy is always low,
// so one query per clock is sustained with no gaps. Each query gives exactly one
// result, o_done high for one cycle with o_hit, after two input stages, one
// stage per quotient bit in the six parallel restoring dividers and four compare
// stages. Results come in query order and the receiver must take them as they
// appear. Write the bound registers only while no query is in flight.
module aabb_line_slab_test_core #(
    parameter int COORD_WIDTH = albt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = albt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [albt_pkg::OP_W-1:0]      i_operation,
    input  logic [COORD_WIDTH-1:0]         i_origin_x,
    input  logic [COORD_WIDTH-1:0]         i_origin_y,
    input  logic [COORD_WIDTH-1:0]         i_origin_z,
    input  logic [COORD_WIDTH-1:0]         i_dir_x,
    input  logic [COORD_WIDTH-1:0]         i_dir_y,
    input  logic [COORD_WIDTH-1:0]         i_dir_z,
    input  logic                           i_cfg_we,
    input  logic [albt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    output logic                           o_done,
    output logic                           o_hit
);
    import albt_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int N   = COORD_WIDTH + FRAC_BITS;
    localparam int LAT = N + 6;

    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // bound registers
    logic signed [W-1:0] r_lo [3];
    logic signed [W-1:0] r_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_X: r_lo[0] <= i_cfg_data;
                CFG_MIN_Y: r_lo[1] <= i_cfg_data;
                CFG_MIN_Z: r_lo[2] <= i_cfg_data;
                CFG_MAX_X: r_hi[0] <= i_cfg_data;
                CFG_MAX_Y: r_hi[1] <= i_cfg_data;
                CFG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: numerators
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    logic signed [W:0]   r_num [LANES];
    logic signed [W-1:0] r_dir [3];
    logic                r_v1;
    logic [OP_W-1:0]     r_op1;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_num[a]   <= (W+1)'(r_lo[a]) - (W+1)'(org[a]);
            r_num[a+3] <= (W+1)'(r_hi[a]) - (W+1)'(org[a]);
            r_dir[a]   <= dir[a];
        end
        r_op1 <= i_operation;
    end

    // stage 2: magnitudes and lane flags
    logic [W-1:0]  r_nmag  [LANES];
    logic [W-1:0]  r_dmag  [LANES];
    t_lane_flags   r_flags [LANES];
    logic          r_v2;
    logic [OP_W-1:0] r_op2;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            logic signed [W:0] nn;
            logic signed [W:0] dd;
            nn = r_num[k];
            dd = (W+1)'(r_dir[k % 3]);
            r_nmag[k]           <= nn[W] ? W'(-nn) : nn[W-1:0];
            r_dmag[k]           <= dd[W] ? W'(-dd) : dd[W-1:0];
            r_flags[k].neg      <= nn[W] ^ dd[W];
            r_flags[k].den_zero <= (dd == '0);
            r_flags[k].num_zero <= (nn == '0);
            r_flags[k].num_pos  <= ~nn[W];
        end
        r_op2 <= r_op1;
    end

    // six dividers in parallel
    logic [W-2:0] dv_q     [LANES];
    logic         dv_sat   [LANES];
    t_lane_flags  dv_flags [LANES];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        albt_divider #(.W(W), .F(FRAC_BITS), .SB(SB_W)) u_div (
            .i_clk (i_clk),
            .i_n   (r_nmag[k]),
            .i_d   (r_dmag[k]),
            .i_sb  (r_flags[k]),
            .o_q   (dv_q[k]),
            .o_sat (dv_sat[k]),
            .o_sb  (dv_flags[k])
        );
    end

    // valid and operation follow the divider depth
    logic            r_vd  [N];
    logic [OP_W-1:0] r_opd [N];

    always_ff @(posedge i_clk) begin
        r_opd[0] <= r_op2;
        for (int i = 1; i < N; i++) begin
            r_opd[i] <= r_opd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else begin
            r_v1    <= accept;
            r_v2    <= r_v1;
            r_vd[0] <= r_v2;
            for (int i = 1; i < N; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
        end
    end

    albt_resolve #(.W(W), .F(FRAC_BITS)) u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vd[N-1]),
        .i_op    (r_opd[N-1]),
        .i_q     (dv_q),
        .i_sat   (dv_sat),
        .i_flags (dv_flags),
        .o_valid (o_done),
        .o_hit   (o_hit)
    );

    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a matching query");

    a_hit_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> !o_hit)
        else $error("hit raised outside a result cycle");
endmodule

// ===== bench/aabb_line_slab_test_core_check.sv =====
`timescale 1ns / 1ps
module aabb_line_slab_test_core_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_dir_z,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        o_done,
    input  logic        o_hit,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_hit_count,
    output int          o_result_count
);
    import albt_pkg::*;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MIN = -64'sd2147483648;
    localparam longint T_ONE   = 64'sd65536;
    localparam longint T_NN    = 64'sd99 <<< 16;
    localparam int     EXP_DEPTH = 256;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    // expected hits in query order, ring indexed by free-running counters
    bit exp_hits [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;

    function automatic longint q16_div(longint num, longint den);
        bit neg;
        longint unsigned n, d, q, r, frac, mag;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            frac = frac << 1;
            if (r >= d) begin
                r = r - d;
                frac = frac | 1;
            end
        end
        if (q > 32768)
            return neg ? NEG_MIN : POS_MAX;
        mag = (q << 16) + frac;
        if (neg)
            return mag >= 64'd2147483648 ? NEG_MIN : -longint'(mag);
        return mag >= 64'd2147483648 ? POS_MAX : longint'(mag);
    endfunction

    function automatic longint slab_t(longint num, longint den, longint degen);
        if (den == 0) begin
            if (num == 0)
                return degen;
            return num > 0 ? POS_MAX : NEG_MIN;
        end
        return q16_div(num, den);
    endfunction

    function automatic bit query_hits(logic [1:0] op, logic signed [31:0] org [3],
                                      logic signed [31:0] dir [3]);
        longint t0, t1, tn, tf, tmin, tmax;
        tmin = 0;
        tmax = 0;
        for (int a = 0; a < 3; a++) begin
            t0 = slab_t(longint'(box_lo[a]) - longint'(org[a]), longint'(dir[a]), 0);
            t1 = slab_t(longint'(box_hi[a]) - longint'(org[a]), longint'(dir[a]), T_NN);
            tn = t0 < t1 ? t0 : t1;
            tf = t0 < t1 ? t1 : t0;
            if (a == 0 || tn > tmin)
                tmin = tn;
            if (a == 0 || tf < tmax)
                tmax = tf;
        end
        if (tmin > tmax)
            return 1'b0;
        case (op)
            OP_SEGMENT: return (tmin >= 0 && tmin <= T_ONE) || (tmax >= 0 && tmax <= T_ONE)
                               || (tmin <= 0 && tmax >= T_ONE);
            OP_RAY:     return tmax >= 0;
            OP_LINE:    return 1'b1;
            default:    return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        bit want;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                box_lo[a] = '0;
                box_hi[a] = '0;
            end
            exp_wr = 0;
            exp_rd = 0;
            o_fail_count = 0;
            o_hit_count = 0;
            o_result_count = 0;
        end else begin
            if (o_done) begin
                if (exp_wr == exp_rd) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with no query pending, hit=%b", $realtime, o_hit);
                end else begin
                    want = exp_hits[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    o_result_count++;
                    if (o_hit)
                        o_hit_count++;
                    if (o_hit !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: hit mismatch, expected %b, got %b",
                                     $realtime, want, o_hit);
                    end
                end
            end
            if (start && !busy) begin
                org[0] = i_origin_x; org[1] = i_origin_y; org[2] = i_origin_z;
                dir[0] = i_dir_x;    dir[1] = i_dir_y;    dir[2] = i_dir_z;
                exp_hits[exp_wr % EXP_DEPTH] = query_hits(i_operation, org, dir);
                exp_wr++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_X: box_lo[0] = i_cfg_data;
                    CFG_MIN_Y: box_lo[1] = i_cfg_data;
                    CFG_MIN_Z: box_lo[2] = i_cfg_data;
                    CFG_MAX_X: box_hi[0] = i_cfg_data;
                    CFG_MAX_Y: box_hi[1] = i_cfg_data;
                    CFG_MAX_Z: box_hi[2] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = exp_wr - exp_rd;
    end

endmodule

// ===== bench/aabb_line_slab_test_core_test.sv =====
`timescale 1ns / 1ps
module aabb_line_slab_test_core_test;
    import albt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_operation = '0;
    logic [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_done, o_hit;
    int fail_count, pending, hit_count, result_count;
    int idle_cycles = 0;
    int query_count = 0;

    always #1 i_clk = ~i_clk;

    aabb_line_slab_test_core dut (.*);

    aabb_line_slab_test_core_check checker_u (
        .i_clk, .i_rst_n, .start, .busy, .i_operation,
        .i_origin_x, .i_origin_y, .i_origin_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_done, .o_hit,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hit_count(hit_count), .o_result_count(result_count)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("** aabb_line_slab_test_core: FAILED **");
            $finish;
        end
    end

    task automatic send_query(logic [1:0] op, logic [31:0] ox, logic [31:0] oy,
                              logic [31:0] oz, logic [31:0] dx, logic [31:0] dy,
                              logic [31:0] dz);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_operation <= op;
        i_origin_x <= ox; i_origin_y <= oy; i_origin_z <= oz;
        i_dir_x <= dx; i_dir_y <= dy; i_dir_z <= dz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        query_count++;
    endtask

    // hold off new queries until every result is back
    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic load_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        logic [31:0] vals [6];
        vals = '{lx, ly, lz, hx, hy, hz};
        drain();
        for (int i = 0; i < 6; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    function automatic logic [31:0] pick_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'($urandom_range(0, 7)) - 32'd3;
            2: return $urandom();
            default: return near_coord();
        endcase
    endfunction

    task automatic random_queries(int count);
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            op = $urandom_range(0, 15) == 0 ? OP_SPARE : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) < 7)
                send_query(op, near_coord(), near_coord(), near_coord(),
                           pick_dir(), pick_dir(), pick_dir());
            else
                send_query(op, $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset box is a single point at the origin
        random_queries(100);

        load_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        // directed: hits, misses, zero directions, saturation, every op
        send_query(OP_SEGMENT, -32'sh0002_0000, '0, '0, 32'h0004_0000, '0, '0);
        send_query(OP_SEGMENT, -32'sh0004_0000, '0, '0, Q_ONE, '0, '0);
        send_query(OP_RAY,     -32'sh0004_0000, '0, '0, Q_ONE, '0, '0);
        send_query(OP_RAY,      32'h0004_0000, '0, '0, Q_ONE, '0, '0);
        send_query(OP_LINE,     32'h0004_0000, '0, '0, Q_ONE, '0, '0);
        send_query(OP_LINE,     32'h0004_0000, 32'h0004_0000, '0, Q_ONE, '0, '0);
        send_query(OP_SPARE,   '0, '0, '0, Q_ONE, Q_ONE, Q_ONE);
        send_query(OP_SEGMENT, -Q_ONE, -Q_ONE, -Q_ONE, '0, '0, '0);
        send_query(OP_RAY,     -Q_ONE, '0, '0, '0, Q_ONE, Q_ONE);
        send_query(OP_SEGMENT, '0, '0, '0, '0, '0, '0);
        send_query(OP_RAY,     32'h0002_0000, '0, '0, '0, Q_ONE, '0);
        send_query(OP_LINE,    Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_query(OP_SEGMENT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        send_query(OP_RAY,     Q_MIN, '0, '0, 32'd1, 32'd1, 32'd1);
        send_query(OP_SEGMENT, -32'sh0002_0000, '0, '0, 32'hffff_ffff, '0, '0);
        send_query(OP_LINE,    '0, '0, '0, Q_MIN, Q_MAX, 32'd1);
        send_query(OP_RAY,     '1, '1, '1, '1, '1, '1);
        send_query(OP_SEGMENT, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        random_queries(350);

        load_box(32'h0000_8000, -32'sh0000_8000, Q_ONE,
                 32'h0002_0000, 32'h0000_8000, 32'h0003_0000);
        random_queries(350);

        load_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        random_queries(300);

        // swapped bounds
        load_box(32'h0002_0000, Q_ONE, '0, -32'sh0002_0000, -Q_ONE, -Q_ONE);
        random_queries(300);

        load_box(Q_MAX, '0, Q_MIN, Q_MAX, '0, Q_MIN);
        random_queries(150);

        load_box(near_coord(), near_coord(), near_coord(),
                 near_coord(), near_coord(), near_coord());
        random_queries(300);

        drain();
        repeat (60) @(negedge i_clk);
        $display("%0d queries over 7 box settings, %0d results checked, %0d hits",
                 query_count, result_count, hit_count);
        if (fail_count == 0 && pending == 0)
            $display("** aabb_line_slab_test_core: PASSED **");
        else
            $display("** aabb_line_slab_test_core: FAILED **");
        $finish;
    end

endmodule
